// ===== hdl/fssr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fssr_pkg
// Types and constants shared by the fan speed step regulator files.
// ----------------------------------------------------------------------------
package fssr_pkg;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned DUTY_W   = 8;
  localparam int unsigned SPEED_W  = 18;
  localparam int unsigned AVG_W    = 22;
  localparam int unsigned TARGET_W = 9;
  localparam int unsigned EDGE_W   = 16;
  localparam int unsigned FRAC_W   = 4;
  localparam int unsigned OUT_W    = 64;

  typedef enum logic [MODE_W-1:0] {
    MODE_EDGE    = 3'd0,
    MODE_TICK    = 3'd1,
    MODE_TARGET  = 3'd2,
    MODE_RAW     = 3'd3,
    MODE_PERCENT = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PUSH,
    ST_MULT,
    ST_CMP,
    ST_STEP,
    ST_AVG,
    ST_DONE
  } state_e;

  // step thresholds, step size is the number of limits exceeded
  localparam int unsigned STEP_COUNT = 6;
  localparam logic [6:0] STEP_LIMIT [STEP_COUNT] = '{
    7'd3, 7'd10, 7'd25, 7'd50, 7'd75, 7'd100
  };

  localparam logic [TARGET_W-1:0] TARGET_MAX  = 9'd270;
  localparam logic [VALUE_W-1:0]  TARGET_MIN  = 16'd5;
  localparam logic [SPEED_W-1:0]  PRESET_GAP  = 18'd40;
  localparam logic [9:0]          PRESET_BIAS = 10'd100;
  localparam logic [9:0]          DIV3_RECIP  = 10'd683;
  localparam int unsigned         DIV3_SHIFT  = 11;
  localparam logic [DUTY_W-1:0]   DUTY_MAX    = 8'd255;
  localparam logic [6:0]          PCT_MAX     = 7'd100;
  localparam logic [15:0]         PCT_RECIP   = 16'd41944;
  localparam int unsigned         PCT_SHIFT   = 22;

endpackage
`default_nettype wire

// ===== hdl/fan_speed_step_regulator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fan_speed_step_regulator
// Edges, writes and idle ticks pass through EXEC and DONE; a regulating tick
// also runs PUSH, MULT, CMP, STEP and AVG, waiting in AVG for the bit-serial
// divider that forms the average. A request is taken only in IDLE.
// A finished result waits in the output register and holds off the next request.
// Reset clears all regulator state; the sample ring needs no clearing.
// ----------------------------------------------------------------------------
module fan_speed_step_regulator
  import fssr_pkg::*;
#(
  parameter int unsigned AVG_WINDOW = 20
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [VALUE_W-1:0] s_axis_tdata,  // value
  input  wire logic [MODE_W-1:0]  s_axis_tuser,  // mode
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // pwm_duty, pwm_written, current_speed, average_speed, target_speed,
  // manual_flag, zero fill
  output logic [OUT_W-1:0]        m_axis_tdata
);

  localparam int unsigned FILL_W = $clog2(AVG_WINDOW + 1);
  localparam int unsigned PTR_W  = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
  localparam int unsigned SUM_W  = SPEED_W + FILL_W;
  localparam int unsigned DVD_W  = SUM_W + FRAC_W;
  localparam int unsigned THR_W  = FILL_W + 7;
  localparam int unsigned PAD_W  = OUT_W - (DUTY_W + 1 + SPEED_W + AVG_W + TARGET_W + 1);

  state_e state_q, state_d;

  mode_e                mode_q;
  logic [VALUE_W-1:0]   value_q;
  logic [EDGE_W-1:0]    edge_q, edge_d;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [FILL_W-1:0]    fill_q, fill_d;
  logic [PTR_W-1:0]     ptr_q, ptr_d;
  logic [DUTY_W-1:0]    duty_q, duty_d;
  logic [SPEED_W-1:0]   speed_q, speed_d;
  logic [TARGET_W-1:0]  target_q, target_d;
  logic                 manual_q, manual_d;
  logic [AVG_W-1:0]     avg_q, avg_d;
  logic                 written_q, written_d;
  logic [SUM_W-1:0]     dist_q, dist_d;
  logic [2:0]           step_q, step_d;
  logic [2:0]           idx_q, idx_d;
  logic                 out_valid_q, out_valid_d;
  logic [OUT_W-1:0]     out_data_q, out_data_d;

  logic [SPEED_W-1:0]   ring [AVG_WINDOW];
  logic [SPEED_W-1:0]   rd_q;
  logic                 ring_we;

  logic                 div_start;
  logic                 div_busy;
  logic [DVD_W-1:0]     div_quo;

  logic                 regulating;
  logic                 out_free;
  logic [SPEED_W-1:0]   sample;
  logic [TARGET_W-1:0]  tgt_clamp;
  logic [SPEED_W-1:0]   tgt_gap;
  logic [9:0]           preset_sum;
  logic [19:0]          preset_prod;
  logic [6:0]           pct;
  logic [14:0]          pct_x;
  logic [30:0]          pct_prod;
  logic [SUM_W-1:0]     scaled;
  logic [THR_W-1:0]     thr;
  logic [DUTY_W:0]      duty_up;

  assign regulating = (target_q != '0) && !manual_q;
  assign out_free   = !out_valid_q || m_axis_tready;
  assign sample     = {edge_q, 2'b00};

  always_comb begin
    tgt_clamp   = (value_q > VALUE_W'(TARGET_MAX)) ? TARGET_MAX : value_q[TARGET_W-1:0];
    tgt_gap     = (SPEED_W'(tgt_clamp) > speed_q) ? SPEED_W'(tgt_clamp) - speed_q
                                                  : speed_q - SPEED_W'(tgt_clamp);
    preset_sum  = 10'(tgt_clamp) + PRESET_BIAS;
    preset_prod = preset_sum * DIV3_RECIP;
    pct         = (value_q > VALUE_W'(PCT_MAX)) ? PCT_MAX : value_q[6:0];
    pct_x       = {pct, 8'b0} - 15'(pct);
    pct_prod    = 31'(pct_x) * 31'(PCT_RECIP);
    scaled      = SUM_W'(target_q) * SUM_W'(fill_q);
    thr         = THR_W'(STEP_LIMIT[idx_q]) * THR_W'(fill_q);
    duty_up     = {1'b0, duty_q} + (DUTY_W + 1)'(step_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = (mode_q == MODE_TICK && regulating) ? ST_PUSH : ST_DONE;
      end
      ST_PUSH: state_d = ST_MULT;
      ST_MULT: state_d = ST_CMP;
      ST_CMP: begin
        if (idx_q == 3'(STEP_COUNT - 1)) begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: state_d = ST_AVG;
      ST_AVG: begin
        if (!div_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    edge_d      = edge_q;
    sum_d       = sum_q;
    fill_d      = fill_q;
    ptr_d       = ptr_q;
    duty_d      = duty_q;
    speed_d     = speed_q;
    target_d    = target_q;
    manual_d    = manual_q;
    avg_d       = avg_q;
    written_d   = written_q;
    dist_d      = dist_q;
    step_d      = step_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    ring_we     = 1'b0;
    div_start   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        written_d = 1'b0;
      end
      ST_EXEC: begin
        case (mode_q)
          MODE_EDGE: edge_d = edge_q + 1'b1;
          MODE_TICK: begin
            if (regulating) begin
              speed_d = sample;
            end
          end
          MODE_TARGET: begin
            manual_d = 1'b0;
            if (value_q < TARGET_MIN) begin
              target_d  = '0;
              duty_d    = '0;
              written_d = 1'b1;
              sum_d     = '0;
              fill_d    = '0;
              ptr_d     = '0;
              avg_d     = '0;
            end else begin
              target_d = tgt_clamp;
              if (tgt_gap > PRESET_GAP) begin
                duty_d    = preset_prod[DIV3_SHIFT +: DUTY_W];
                written_d = 1'b1;
              end
            end
          end
          MODE_RAW: begin
            manual_d  = 1'b1;
            duty_d    = (value_q > VALUE_W'(DUTY_MAX)) ? DUTY_MAX : value_q[DUTY_W-1:0];
            written_d = 1'b1;
          end
          MODE_PERCENT: begin
            manual_d  = 1'b1;
            duty_d    = pct_prod[PCT_SHIFT +: DUTY_W];
            written_d = 1'b1;
          end
          default: ;
        endcase
      end
      ST_PUSH: begin
        ring_we = 1'b1;
        edge_d  = '0;
        if (fill_q >= FILL_W'(AVG_WINDOW)) begin
          sum_d = sum_q - SUM_W'(rd_q) + SUM_W'(speed_q);
        end else begin
          fill_d = fill_q + 1'b1;
          sum_d  = sum_q + SUM_W'(speed_q);
        end
        ptr_d = (ptr_q == PTR_W'(AVG_WINDOW - 1)) ? '0 : ptr_q + 1'b1;
      end
      ST_MULT: begin
        div_start = 1'b1;
        dist_d    = (scaled > sum_q) ? scaled - sum_q : sum_q - scaled;
        step_d    = '0;
        idx_d     = '0;
      end
      ST_CMP: begin
        if (dist_q > SUM_W'(thr)) begin
          step_d = idx_q + 1'b1;
        end
        idx_d = idx_q + 1'b1;
      end
      ST_STEP: begin
        if (step_q != '0) begin
          written_d = 1'b1;
          if (SPEED_W'(target_q) > speed_q) begin
            duty_d = duty_up[DUTY_W] ? DUTY_MAX : duty_up[DUTY_W-1:0];
          end else begin
            duty_d = (duty_q < DUTY_W'(step_q)) ? '0 : duty_q - DUTY_W'(step_q);
          end
        end
      end
      ST_AVG: begin
        if (!div_busy) begin
          avg_d = div_quo[AVG_W-1:0];
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {PAD_W'(0), manual_q, target_q, avg_q, speed_q, written_q, duty_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      edge_q      <= '0;
      sum_q       <= '0;
      fill_q      <= '0;
      ptr_q       <= '0;
      duty_q      <= '0;
      speed_q     <= '0;
      target_q    <= '0;
      manual_q    <= 1'b0;
      avg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      edge_q      <= edge_d;
      sum_q       <= sum_d;
      fill_q      <= fill_d;
      ptr_q       <= ptr_d;
      duty_q      <= duty_d;
      speed_q     <= speed_d;
      target_q    <= target_d;
      manual_q    <= manual_d;
      avg_q       <= avg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      mode_q  <= mode_e'(s_axis_tuser);
      value_q <= s_axis_tdata;
    end
    written_q  <= written_d;
    dist_q     <= dist_d;
    step_q     <= step_d;
    idx_q      <= idx_d;
    out_data_q <= out_data_d;
  end

  // sample ring
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring[ptr_q] <= speed_q;
    end
    rd_q <= ring[ptr_q];
  end

  fssr_div #(
    .DIVIDEND_W(DVD_W),
    .DIVISOR_W (FILL_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i({sum_q, FRAC_W'(0)}),
    .divisor_i (fill_q),
    .busy_o    (div_busy),
    .quotient_o(div_quo)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire

// ===== hdl/fssr_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fssr_div
// Restoring divider, one quotient bit per cycle while busy.
// ----------------------------------------------------------------------------
module fssr_div #(
  parameter int unsigned DIVIDEND_W = 27,
  parameter int unsigned DIVISOR_W  = 5
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DIVISOR_W-1:0]  divisor_i,
  output logic                       busy_o,
  output logic [DIVIDEND_W-1:0]      quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  divisor_q;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  always_comb begin
    shifted = {rem_q, quo_q[DIVIDEND_W-1]};
    fits    = shifted >= {1'b0, divisor_q};
    diff    = shifted - {1'b0, divisor_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DIVIDEND_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q     <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire
